@@ rtl/core/ptt_pkg.sv @@
// Package for the programmable transition-table state machine.
// Holds the item kind codes, result status codes and sequencer states.
// No dependencies.
package ptt_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATE_W  = 8;
  localparam int unsigned EVENT_W  = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TRANS_W  = 2 * STATE_W + EVENT_W;

  typedef enum logic [KIND_W-1:0] {
    K_DEF_STATE = 2'd0,
    K_DEF_TRANS = 2'd1,
    K_SET_STATE = 2'd2,
    K_EVENT     = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_DUPLICATE     = 3'd1,
    ST_UNKNOWN       = 3'd2,
    ST_LOCKED        = 3'd3,
    ST_FULL          = 3'd4,
    ST_NO_TRANSITION = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } seq_state_t;

endpackage

@@ rtl/core/ptt_in_if.sv @@
// Input channel of the transition-table state machine: valid/ready plus one item.
// Depends on ptt_pkg for field widths.
interface ptt_in_if;
  logic                         valid;
  logic                         ready;
  logic [ptt_pkg::KIND_W-1:0]   kind;
  logic [ptt_pkg::STATE_W-1:0]  state_a;
  logic [ptt_pkg::STATE_W-1:0]  state_b;
  logic [ptt_pkg::EVENT_W-1:0]  event_code;

  modport source (output valid, kind, state_a, state_b, event_code, input ready);
  modport sink   (input valid, kind, state_a, state_b, event_code, output ready);
endinterface

@@ rtl/core/ptt_out_if.sv @@
// Output channel of the transition-table state machine: valid/ready plus one result.
// Depends on ptt_pkg for field widths.
interface ptt_out_if;
  logic                          valid;
  logic                          ready;
  logic [ptt_pkg::STATUS_W-1:0]  status;
  logic [ptt_pkg::STATE_W-1:0]   current_state;
  logic                          moved;

  modport source (output valid, status, current_state, moved, input ready);
  modport sink   (input valid, status, current_state, moved, output ready);
endinterface

@@ rtl/core/programmable_transition_table_fsm_core.sv @@
// Programmable transition-table state machine, top level.
// Each taken item passes a scan state, which reads the entries below the count (defined
// states, or stored transitions for an event) and stops at the first matching transition
// for an event, then a finishing state; a definition refused while locked skips the scan.
// One item at a time; the finishing state waits while the result register is full.
// Reset clears counts, lock flag and current state; memories are kept.
module programmable_transition_table_fsm_core #(
  parameter int unsigned STATE_SLOTS      = 16,
  parameter int unsigned TRANSITION_SLOTS = 32
) (
  input  logic      clk,
  input  logic      rst,
  ptt_in_if.sink    item_in,
  ptt_out_if.source result_out
);
  import ptt_pkg::*;

  // Count registers hold 0..SLOTS, memory addresses index 0..SLOTS-1.
  localparam int unsigned SCW = $clog2(STATE_SLOTS + 1);
  localparam int unsigned TCW = $clog2(TRANSITION_SLOTS + 1);
  localparam int unsigned SIW = (STATE_SLOTS > 1) ? $clog2(STATE_SLOTS) : 1;
  localparam int unsigned TIW = (TRANSITION_SLOTS > 1) ? $clog2(TRANSITION_SLOTS) : 1;
  localparam logic [SCW-1:0] S_MAX = SCW'(STATE_SLOTS);
  localparam logic [TCW-1:0] T_MAX = TCW'(TRANSITION_SLOTS);

  seq_state_t st, st_next;

  // Latched item.
  kind_t              kind_r;
  logic [STATE_W-1:0] a_r;
  logic [STATE_W-1:0] b_r;
  logic [EVENT_W-1:0] ev_r;

  // Architectural state kept in flip-flops; the tables live in the two memories.
  logic [SCW-1:0]     scount;
  logic [TCW-1:0]     tcount;
  logic               locked;
  logic [STATE_W-1:0] present;

  // Scan machinery.
  logic [SCW-1:0]     sidx;
  logic [TCW-1:0]     tidx;
  logic               pend;
  logic               found_a;
  logic               found_b;
  logic               hit;
  logic [STATE_W-1:0] hit_to;

  // Output register.
  logic               out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [STATE_W-1:0] out_state;
  logic               out_moved;

  // Memory ports.
  logic               s_we;
  logic [STATE_W-1:0] s_rdata;
  logic               t_we;
  logic [TRANS_W-1:0] t_wdata;
  logic [TRANS_W-1:0] t_rdata;

  // Combinational helpers.
  logic               accept;
  logic               scan_trans;
  logic               s_issue;
  logic               t_issue;
  logic               t_match;
  logic               scan_done;
  logic               out_free;
  logic               commit;
  status_t            res_status;
  logic [STATE_W-1:0] res_state;
  logic               res_moved;

  // The state memory holds defined identifiers in definition order; the transition
  // memory holds {from, to, event} in insertion order. Writes only happen in the
  // finishing cycle, after all reads of the item, so no forwarding is needed.
  ptt_ram #(.WIDTH(STATE_W), .DEPTH(STATE_SLOTS)) u_state_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (scount[SIW-1:0]),
    .wdata (a_r),
    .raddr (sidx[SIW-1:0]),
    .rdata (s_rdata)
  );

  ptt_ram #(.WIDTH(TRANS_W), .DEPTH(TRANSITION_SLOTS)) u_trans_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (tcount[TIW-1:0]),
    .wdata (t_wdata),
    .raddr (tidx[TIW-1:0]),
    .rdata (t_rdata)
  );

  assign t_wdata = {a_r, b_r, ev_r};

  // An event scans transitions; every other kind scans the defined states.
  assign scan_trans = (kind_r == K_EVENT);
  assign s_issue    = (st == S_SCAN) && !scan_trans && (sidx < scount);
  assign t_issue    = (st == S_SCAN) && scan_trans && (tidx < tcount);
  // Read data arrives in the cycle after the address, flagged by pend.
  assign t_match    = pend && (t_rdata[TRANS_W-1 -: STATE_W] == present) &&
                      (t_rdata[EVENT_W-1:0] == ev_r);
  // The scan ends once every entry below the count has been compared, or at the
  // first matching transition for an event.
  assign scan_done  = (!pend && !s_issue && !t_issue) || (scan_trans && t_match);

  assign accept     = item_in.valid && item_in.ready;
  // The result register frees up in the same cycle that its item is taken.
  assign out_free   = !out_valid || result_out.ready;
  assign commit     = (st == S_FINISH) && out_free;

  // Next-state logic.
  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE: begin
        if (item_in.valid) begin
          // Definitions while locked are refused without a scan.
          if (locked && (kind_t'(item_in.kind) == K_DEF_STATE ||
                         kind_t'(item_in.kind) == K_DEF_TRANS)) begin
            st_next = S_FINISH;
          end else begin
            st_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          st_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  // Result and write-back decisions, taken from the flags gathered by the scan.
  always_comb begin
    res_status = ST_OK;
    res_state  = present;
    res_moved  = 1'b0;
    s_we       = 1'b0;
    t_we       = 1'b0;
    case (kind_r)
      K_DEF_STATE: begin
        if (locked) begin
          res_status = ST_LOCKED;
        end else if (found_a) begin
          res_status = ST_DUPLICATE;
        end else if (scount >= S_MAX) begin
          res_status = ST_FULL;
        end else begin
          s_we = commit;
        end
      end
      K_DEF_TRANS: begin
        if (locked) begin
          res_status = ST_LOCKED;
        end else if (!found_a || !found_b) begin
          res_status = ST_UNKNOWN;
        end else if (tcount >= T_MAX) begin
          res_status = ST_FULL;
        end else begin
          t_we = commit;
        end
      end
      K_SET_STATE: begin
        if (!found_a) begin
          res_status = ST_UNKNOWN;
        end else begin
          res_state = a_r;
        end
      end
      default: begin
        if (hit) begin
          res_state = hit_to;
          res_moved = 1'b1;
        end else begin
          res_status = ST_NO_TRANSITION;
        end
      end
    endcase
  end

  // No item is taken while reset is held.
  assign item_in.ready = (st == S_IDLE) && !rst;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      scount    <= '0;
      tcount    <= '0;
      locked    <= 1'b0;
      present   <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      st <= st_next;
      if (st == S_SCAN) begin
        pend <= s_issue || t_issue;
      end else begin
        pend <= 1'b0;
      end
      // A new result may replace the one taken in the same cycle.
      if (commit) begin
        out_valid <= 1'b1;
      end else if (result_out.valid && result_out.ready) begin
        out_valid <= 1'b0;
      end
      if (commit) begin
        present   <= res_state;
        if (s_we) begin
          scount <= scount + SCW'(1);
        end
        if (t_we) begin
          tcount <= tcount + TCW'(1);
        end
        // Every applied event locks the definitions, matched or not.
        if (kind_r == K_EVENT) begin
          locked <= 1'b1;
        end
      end
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= kind_t'(item_in.kind);
      a_r     <= item_in.state_a;
      b_r     <= item_in.state_b;
      ev_r    <= item_in.event_code;
      sidx    <= '0;
      tidx    <= '0;
      found_a <= 1'b0;
      found_b <= 1'b0;
      hit     <= 1'b0;
    end else if (st == S_SCAN) begin
      if (s_issue) begin
        sidx <= sidx + SCW'(1);
      end
      if (t_issue) begin
        tidx <= tidx + TCW'(1);
      end
      if (pend && !scan_trans) begin
        if (s_rdata == a_r) begin
          found_a <= 1'b1;
        end
        if (s_rdata == b_r) begin
          found_b <= 1'b1;
        end
      end
      if (t_match) begin
        hit    <= 1'b1;
        hit_to <= t_rdata[EVENT_W +: STATE_W];
      end
    end
    if (commit) begin
      out_status <= res_status;
      out_state  <= res_state;
      out_moved  <= res_moved;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.status        = out_status;
  assign result_out.current_state = out_state;
  assign result_out.moved         = out_moved;

endmodule

@@ rtl/core/ptt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ptt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
